// File: rtl/coff_pkg.sv
package coff_pkg;

    localparam int FRAME_W  = 16;
    localparam int SIDE_W   = 2;
    localparam int STRIKE_W = 41;
    localparam int STAMP_W  = 62;
    localparam int AGE_W    = STRIKE_W + 1;
    localparam int DIFF_W   = STRIKE_W + 2;
    localparam int ID_W     = 32;
    localparam int IN_W     = 248;
    localparam int OUT_W    = 48;

    localparam logic [SIDE_W-1:0] SIDE_POS = 2'b01;
    localparam logic [SIDE_W-1:0] SIDE_NEG = 2'b11;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_INVALID   = 2'd1,
        ST_STALE     = 2'd2,
        ST_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_FRAME     = 3'd1,
        RSN_SIDE      = 3'd2,
        RSN_BAD_VALUE = 3'd3,
        RSN_EXPIRED   = 3'd4,
        RSN_OLD_TASK  = 3'd5,
        RSN_SIDE_CHG  = 3'd6,
        RSN_REVISION  = 3'd7
    } reason_t;

    typedef struct packed {
        reason_t               early;
        logic [SIDE_W-1:0]     side;
        logic [STRIKE_W-1:0]   strike;
        logic [AGE_W-1:0]      age;
        logic [ID_W-1:0]       task_num;
        logic [ID_W-1:0]       rev_num;
    } entry_t;

endpackage

// File: rtl/command_order_freshness_filter_top.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata, 248 bits, one command request
// m_        out  m_tvalid/m_tready  m_tdata, 48 bits, one verdict request
// cfg_      in   cfg_we             cfg_wdata, expected frame code
//
// one request per cycle sustained while m_tready stays high
// front computes the stateless checks and transit age, back does the state checks
// a verdict passes through the queue register and then the verdict output register
// reset clears the queue, the task history and the frame code to zero
// s_tready drops only when the queue is full, the back stalls on m_tready alone
module command_order_freshness_filter_top import coff_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [FRAME_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // frame_code, strike_side, values_finite, strike_time_ns, source_stamp,
    // now_stamp, task_number, revision_number
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status, reason_code, adjusted_strike_ns, zero pad
    output logic [OUT_W-1:0]   m_tdata
);

    entry_t              front_entry;
    entry_t              q_head;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    status_t             out_status;
    reason_t             out_reason;
    logic [STRIKE_W-1:0] out_adj;

    assign s_tready = !q_full;

    coff_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .entry     (front_entry)
    );

    coff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid && s_tready),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    coff_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_reason (out_reason),
        .out_adj    (out_adj)
    );

    assign m_tdata = {2'b00, out_adj, out_reason, out_status};

endmodule

// File: rtl/coff_front.sv
module coff_front import coff_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [FRAME_W-1:0] cfg_wdata,
    input  logic [IN_W-1:0]    in_data,
    output entry_t             entry
);

    logic [FRAME_W-1:0]  exp_frame_reg;
    logic [FRAME_W-1:0]  frame;
    logic [SIDE_W-1:0]   side;
    logic                finite;
    logic [STRIKE_W-1:0] strike;
    logic [STAMP_W-1:0]  src;
    logic [STAMP_W-1:0]  now;
    logic [STAMP_W:0]    span;
    logic [STAMP_W-1:0]  age_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_frame_reg <= '0;
        end else if (cfg_we) begin
            exp_frame_reg <= cfg_wdata;
        end
    end

    assign frame  = in_data[15:0];
    assign side   = in_data[17:16];
    assign finite = in_data[18];
    assign strike = in_data[59:19];
    assign src    = in_data[121:60];
    assign now    = in_data[183:122];

    assign span = {1'b0, now} - {1'b0, src};

    always_comb begin
        if (src != '0 && !span[STAMP_W]) begin
            age_full = span[STAMP_W-1:0];
        end else begin
            age_full = '0;
        end
    end

    always_comb begin
        entry.side     = side;
        entry.strike   = strike;
        entry.task_num = in_data[215:184];
        entry.rev_num  = in_data[247:216];
        // clamp age, anything this large saturates the result anyway
        if (age_full[STAMP_W-1:STRIKE_W] != '0) begin
            entry.age = {1'b1, {STRIKE_W{1'b0}}};
        end else begin
            entry.age = {1'b0, age_full[STRIKE_W-1:0]};
        end
        if (frame != exp_frame_reg) begin
            entry.early = RSN_FRAME;
        end else if (side != SIDE_POS && side != SIDE_NEG) begin
            entry.early = RSN_SIDE;
        end else if (!finite || strike[STRIKE_W-1]) begin
            entry.early = RSN_BAD_VALUE;
        end else begin
            entry.early = RSN_OK;
        end
    end

endmodule

// File: rtl/coff_queue.sv
module coff_queue import coff_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/coff_back.sv
module coff_back import coff_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  entry_t              q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output status_t             out_status,
    output reason_t             out_reason,
    output logic [STRIKE_W-1:0] out_adj
);

    logic                task_seen_reg, task_seen_next;
    logic [ID_W-1:0]     last_task_reg, last_task_next;
    logic [ID_W-1:0]     last_rev_reg, last_rev_next;
    logic [SIDE_W-1:0]   locked_side_reg, locked_side_next;

    logic                valid_reg;
    status_t             status_reg, status_next;
    reason_t             reason_reg, reason_next;
    logic [STRIKE_W-1:0] adj_reg, adj_next;

    logic [DIFF_W-1:0]   diff;
    logic [STRIKE_W-1:0] adj_sat;
    logic                expired;
    logic                accept;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    assign diff = {2'b00, q_head.strike} - {1'b0, q_head.age};
    assign expired = diff[DIFF_W-1] || (diff == '0);

    always_comb begin
        if (diff[DIFF_W-1] && !(diff[DIFF_W-2] && diff[DIFF_W-3])) begin
            adj_sat = {1'b1, {(STRIKE_W-1){1'b0}}};
        end else begin
            adj_sat = diff[STRIKE_W-1:0];
        end
    end

    always_comb begin
        accept      = 1'b0;
        status_next = ST_INVALID;
        reason_next = q_head.early;
        adj_next    = adj_sat;
        if (q_head.early != RSN_OK) begin
            adj_next = '0;
        end else if (expired) begin
            status_next = ST_STALE;
            reason_next = RSN_EXPIRED;
        end else if (task_seen_reg && q_head.task_num < last_task_reg) begin
            status_next = ST_STALE;
            reason_next = RSN_OLD_TASK;
        end else if (task_seen_reg && q_head.task_num == last_task_reg
                     && q_head.side != locked_side_reg) begin
            status_next = ST_INVALID;
            reason_next = RSN_SIDE_CHG;
        end else if (task_seen_reg && q_head.task_num == last_task_reg
                     && q_head.rev_num <= last_rev_reg) begin
            status_next = (q_head.rev_num == last_rev_reg) ? ST_DUPLICATE : ST_STALE;
            reason_next = RSN_REVISION;
        end else begin
            accept      = 1'b1;
            status_next = ST_ACCEPTED;
            reason_next = RSN_OK;
        end
    end

    always_comb begin
        task_seen_next   = task_seen_reg;
        last_task_next   = last_task_reg;
        last_rev_next    = last_rev_reg;
        locked_side_next = locked_side_reg;
        if (q_pop && accept) begin
            if (!task_seen_reg || q_head.task_num > last_task_reg) begin
                last_task_next   = q_head.task_num;
                locked_side_next = q_head.side;
            end
            last_rev_next  = q_head.rev_num;
            task_seen_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_seen_reg   <= 1'b0;
            last_task_reg   <= '0;
            last_rev_reg    <= '0;
            locked_side_reg <= '0;
            valid_reg       <= 1'b0;
        end else begin
            task_seen_reg   <= task_seen_next;
            last_task_reg   <= last_task_next;
            last_rev_reg    <= last_rev_next;
            locked_side_reg <= locked_side_next;
            if (q_pop) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            status_reg <= status_next;
            reason_reg <= reason_next;
            adj_reg    <= adj_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_reason = reason_reg;
    assign out_adj    = adj_reg;

endmodule

// File: bench/testbench.sv
module testbench;
    import coff_pkg::*;

    // revision_number, task_number, now_stamp, source_stamp, strike_time_ns,
    // values_finite, strike_side, frame_code (frame_code in the lowest bits)
    typedef struct packed {
        logic [ID_W-1:0]     rev;
        logic [ID_W-1:0]     task_id;
        logic [STAMP_W-1:0]  now;
        logic [STAMP_W-1:0]  src;
        logic [STRIKE_W-1:0] strike;
        logic                finite;
        logic [SIDE_W-1:0]   side;
        logic [FRAME_W-1:0]  frame;
    } command_t;

    // zero pad, adjusted_strike_ns, reason_code, status
    typedef struct packed {
        logic [OUT_W-47:0]   pad;
        logic [STRIKE_W-1:0] adj;
        reason_t             reason;
        status_t             status;
    } verdict_t;

    typedef enum {
        CMD_NEXT_REV, CMD_NEW_TASK, CMD_REPEAT_REV, CMD_OLD_REV, CMD_SIDE_FLIP,
        CMD_OLD_TASK, CMD_EXPIRED, CMD_FRAME, CMD_BAD_SIDE, CMD_BAD_VALUE, CMD_NOISE
    } cmd_kind_t;

    class verdict_tracker;
        verdict_t           pending_verdicts[$];
        int                 mismatches;
        logic [FRAME_W-1:0] frame_code;
        logic               seen_task;
        logic [ID_W-1:0]    last_task;
        logic [ID_W-1:0]    last_rev;
        logic [SIDE_W-1:0]  locked_side;

        function new();
            mismatches  = 0;
            frame_code  = '0;
            seen_task   = 1'b0;
            last_task   = '0;
            last_rev    = '0;
            locked_side = '0;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void screen_command(command_t c);
            verdict_t           v;
            logic [STAMP_W-1:0] age;
            longint             adj_full;
            v = '0;
            v.status = ST_INVALID;
            if (c.frame != frame_code) begin
                v.reason = RSN_FRAME;
            end else if (c.side != SIDE_POS && c.side != SIDE_NEG) begin
                v.reason = RSN_SIDE;
            end else if (!c.finite || c.strike[STRIKE_W-1]) begin
                v.reason = RSN_BAD_VALUE;
            end else begin
                age = (c.src != 0 && c.now >= c.src) ? c.now - c.src : '0;
                adj_full = longint'({23'd0, c.strike}) - longint'({2'd0, age});
                if (adj_full < -64'sd1099511627776) begin
                    v.adj = {1'b1, 40'd0};
                end else begin
                    v.adj = adj_full[STRIKE_W-1:0];
                end
                if (adj_full <= 0) begin
                    v.status = ST_STALE;
                    v.reason = RSN_EXPIRED;
                end else if (seen_task && c.task_id < last_task) begin
                    v.status = ST_STALE;
                    v.reason = RSN_OLD_TASK;
                end else if (seen_task && c.task_id == last_task
                             && c.side != locked_side) begin
                    v.status = ST_INVALID;
                    v.reason = RSN_SIDE_CHG;
                end else if (seen_task && c.task_id == last_task && c.rev <= last_rev) begin
                    v.status = (c.rev == last_rev) ? ST_DUPLICATE : ST_STALE;
                    v.reason = RSN_REVISION;
                end else begin
                    v.status = ST_ACCEPTED;
                    v.reason = RSN_OK;
                    if (!seen_task || c.task_id > last_task) begin
                        last_task   = c.task_id;
                        locked_side = c.side;
                    end
                    last_rev  = c.rev;
                    seen_task = 1'b1;
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("verdict %h with no request outstanding", got));
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status || got.reason !== want.reason ||
                    got.adj !== want.adj || got.pad !== want.pad) begin
                    report($sformatf(
                        "status %0d want %0d, reason %0d want %0d, adj %0d want %0d, pad %b",
                        got.status, want.status, got.reason, want.reason,
                        $signed(got.adj), $signed(want.adj), got.pad));
                end
            end
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [FRAME_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    verdict_tracker     tracker;
    logic [FRAME_W-1:0] cur_frame;
    logic [ID_W-1:0]    gen_task;
    logic [ID_W-1:0]    gen_rev;
    logic [SIDE_W-1:0]  gen_side;
    logic               burst;

    command_order_freshness_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic command_t make_cmd(logic [FRAME_W-1:0] frame, logic [SIDE_W-1:0] side,
                                          logic finite, logic [STRIKE_W-1:0] strike,
                                          logic [STAMP_W-1:0] src, logic [STAMP_W-1:0] now,
                                          logic [ID_W-1:0] task_id, logic [ID_W-1:0] rev);
        command_t c;
        c.frame   = frame;
        c.side    = side;
        c.finite  = finite;
        c.strike  = strike;
        c.src     = src;
        c.now     = now;
        c.task_id = task_id;
        c.rev     = rev;
        return c;
    endfunction

    function automatic cmd_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return CMD_NEXT_REV;
        if (r < 72) return CMD_NEW_TASK;
        if (r < 76) return CMD_REPEAT_REV;
        if (r < 79) return CMD_OLD_REV;
        if (r < 82) return CMD_SIDE_FLIP;
        if (r < 85) return CMD_OLD_TASK;
        if (r < 88) return CMD_EXPIRED;
        if (r < 91) return CMD_FRAME;
        if (r < 94) return CMD_BAD_SIDE;
        if (r < 97) return CMD_BAD_VALUE;
        return CMD_NOISE;
    endfunction

    // well-formed command for the current task, then bent by kind
    function automatic command_t next_command(cmd_kind_t kind);
        command_t            c;
        logic [STRIKE_W-1:0] strike;
        logic [STAMP_W-1:0]  age;
        logic [STAMP_W-1:0]  now;
        logic [STAMP_W-1:0]  big_age;
        strike = STRIKE_W'(rand64());
        strike[STRIKE_W-1] = 1'b0;
        strike = strike >> $urandom_range(0, 39);
        if (strike == '0) strike = STRIKE_W'(1);
        age = STAMP_W'(rand64() % 64'(strike));
        now = STAMP_W'(rand64());
        if (now < age) now = now + age;
        c = make_cmd(cur_frame, gen_side, 1'b1, strike, now - age, now, gen_task,
                     gen_rev + $urandom_range(1, 3));
        case ($urandom_range(0, 15))
            0: c.src = '0;
            1: c.src = now + $urandom_range(1, 1000);
            default: ;
        endcase
        case (kind)
            CMD_NEW_TASK: begin
                if ($urandom_range(0, 7) == 0 && gen_task < 32'hF000_0000) begin
                    c.task_id = gen_task + $urandom_range(1, 1 << 24);
                end else begin
                    c.task_id = gen_task + $urandom_range(1, 5);
                end
                c.side = $urandom_range(0, 1) ? SIDE_POS : SIDE_NEG;
                c.rev  = $urandom >> $urandom_range(0, 31);
            end
            CMD_REPEAT_REV: c.rev = gen_rev;
            CMD_OLD_REV: c.rev = gen_rev - $urandom_range(1, 100);
            CMD_SIDE_FLIP: c.side = (gen_side == SIDE_POS) ? SIDE_NEG : SIDE_POS;
            CMD_OLD_TASK: c.task_id = gen_task - $urandom_range(1, 100);
            CMD_EXPIRED: begin
                big_age = $urandom_range(0, 1) ? STAMP_W'(rand64())
                        : {21'd0, strike} + STAMP_W'($urandom_range(0, 3));
                c.now = STAMP_W'(rand64());
                if (c.now < big_age) c.now = big_age;
                c.src = c.now - big_age;
                if (c.src == '0) begin
                    c.src = STAMP_W'(1);
                    c.now = c.now + 1'b1;
                end
            end
            CMD_FRAME: c.frame = cur_frame ^ FRAME_W'($urandom_range(1, 65535));
            CMD_BAD_SIDE: c.side = $urandom_range(0, 1) ? 2'b00 : 2'b10;
            CMD_BAD_VALUE: begin
                if ($urandom_range(0, 1)) begin
                    c.finite = 1'b0;
                end else begin
                    c.strike = STRIKE_W'(rand64());
                    c.strike[STRIKE_W-1] = 1'b1;
                end
            end
            CMD_NOISE: begin
                c = command_t'(IN_W'({rand64(), rand64(), rand64(), rand64()}));
                if ($urandom_range(0, 1)) c.frame = cur_frame;
            end
            default: ;
        endcase
        if (kind == CMD_NEXT_REV || kind == CMD_NEW_TASK) begin
            gen_task = c.task_id;
            gen_rev  = c.rev;
            gen_side = c.side;
        end
        return c;
    endfunction

    task automatic idle_sender(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_command(command_t c);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        tracker.screen_command(c);
    endtask

    task automatic wait_for_verdicts();
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_frame_code(logic [FRAME_W-1:0] code);
        idle_sender(1);
        wait_for_verdicts();
        repeat (3) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        tracker.frame_code = code;
        cur_frame = code;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            n = pick_gap();
            repeat (n) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            n = $urandom_range(1, 8);
            repeat (n) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_verdict(verdict_t'(m_tdata));
        end
    end

    initial begin
        #5_000_000;
        $display("command_order_freshness_filter_top verification failed");
        $finish;
    end

    initial begin
        logic [FRAME_W-1:0] code;
        tracker   = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cur_frame = '0;
        burst     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // frame code still at its reset value
        send_command(make_cmd(16'hFFFF, SIDE_POS, 1'b1, 41'd1000, 62'd0, 62'd0, 32'd0, 32'd0));
        send_command(make_cmd(16'h0000, 2'b00, 1'b1, 41'd1000, 62'd0, 62'd0, 32'd0, 32'd0));
        send_command(make_cmd(16'h0000, 2'b10, 1'b1, 41'd1000, 62'd0, 62'd0, 32'd0, 32'd0));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b0, 41'd1000, 62'd0, 62'd0, 32'd0, 32'd0));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, {1'b1, 40'd0}, 62'd0, 62'd0,
                              32'd0, 32'd0));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, 41'd0, 62'd0, 62'd0, 32'd0, 32'd0));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, {1'b0, {40{1'b1}}}, 62'd0, 62'd5,
                              32'd0, 32'd0));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, {1'b0, {40{1'b1}}}, 62'd0, 62'd5,
                              32'd0, 32'd0));
        send_command(make_cmd(16'h0000, SIDE_NEG, 1'b1, 41'd1000, 62'd0, 62'd0, 32'd0, 32'd1));
        // send stamp in the future
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, 41'd1000, 62'd500, 62'd100,
                              32'd0, 32'd1));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, 41'd1000, 62'd0, 62'd0, 32'd0, 32'd0));
        // transit age far beyond the range, saturates
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, 41'd1000, 62'd1, {62{1'b1}},
                              32'd0, 32'd2));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, 41'd1000, 62'd4000, 62'd5000,
                              32'd0, 32'd2));
        send_command(make_cmd(16'h0000, SIDE_POS, 1'b1, 41'd1000, 62'd4001, 62'd5000,
                              32'd0, 32'd2));
        send_command(make_cmd(16'h0000, SIDE_NEG, 1'b1, 41'd1000, 62'd0, 62'd0,
                              32'd7, 32'hFFFF_FFFF));
        send_command(make_cmd(16'h0000, SIDE_NEG, 1'b1, 41'd1000, 62'd0, 62'd0, 32'd3, 32'd5));
        send_command(make_cmd(16'h0000, SIDE_NEG, 1'b1, 41'd1000, 62'd0, 62'd0,
                              32'd7, 32'hFFFF_FFFF));
        gen_task = 32'd7;
        gen_rev  = 32'hFFFF_FFFF;
        gen_side = SIDE_NEG;

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: code = 16'hFFFF;
                2: code = 16'h0000;
                default: code = FRAME_W'($urandom_range(0, 65535));
            endcase
            write_frame_code(code);
            for (int i = 0; i < 120; i++) begin
                if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                if (i == 60) begin
                    idle_sender(1);
                    wait_for_verdicts();
                end
                idle_sender(burst ? 0 : pick_gap());
                send_command(next_command(i == 0 ? CMD_NEW_TASK : pick_kind()));
            end
        end

        // top of the task id range
        send_command(make_cmd(cur_frame, SIDE_NEG, 1'b1, {1'b0, {40{1'b1}}}, 62'd10, 62'd20,
                              32'hFFFF_FFFF, 32'd0));
        send_command(make_cmd(cur_frame, SIDE_NEG, 1'b1, {1'b0, {40{1'b1}}}, 62'd0, 62'd0,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(make_cmd(cur_frame, SIDE_NEG, 1'b1, 41'd77, 62'd0, 62'd0,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(make_cmd(cur_frame, SIDE_POS, 1'b1, 41'd77, 62'd0, 62'd0,
                              32'hFFFF_FFFF, 32'd5));
        send_command(make_cmd(cur_frame, SIDE_NEG, 1'b1, 41'd77, 62'd0, 62'd0, 32'd0, 32'd5));

        idle_sender(1);
        wait_for_verdicts();
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("command_order_freshness_filter_top verification clean");
        end else begin
            $display("command_order_freshness_filter_top verification failed");
        end
        $finish;
    end

endmodule

// File: command_order_freshness_filter_top.f
rtl/coff_pkg.sv
rtl/coff_front.sv
rtl/coff_queue.sv
rtl/coff_back.sv
rtl/command_order_freshness_filter_top.sv
bench/testbench.sv
